/* src/sbp_pkg.sv */
// Shared types and constants for the sorted block pool.
package sbp_pkg;

  // Pool geometry
  localparam int NODES  = 8;
  localparam int NODE_W = 3;
  localparam int CNT_W  = 4;
  localparam int SER_W  = 32;

  // Operation codes
  localparam logic [1:0] MODE_ALLOC   = 2'd0;
  localparam logic [1:0] MODE_POP_SER = 2'd1;
  localparam logic [1:0] MODE_POP_HD  = 2'd2;
  localparam logic [1:0] MODE_FREE    = 2'd3;

  // Request transaction
  typedef struct packed {
    logic [1:0]        mode;
    logic [SER_W-1:0]  serial_number;
    logic              dup_check;
    logic [NODE_W-1:0] node_index;
  } sbp_in_t;

  // Result transaction
  typedef struct packed {
    logic              ok;
    logic [NODE_W-1:0] node_out;
    logic [CNT_W-1:0]  used_count;
    logic [CNT_W-1:0]  free_count;
  } sbp_out_t;

  // Compare unit flags
  typedef struct packed {
    logic eq;    // stored serial equals key
    logic stop;  // insertion point found ahead of this entry
  } sbp_cmp_t;

endpackage

/* src/sbp_cmp.sv */
// Shared serial compare unit used by every list walk.
module sbp_cmp (
  input  logic [sbp_pkg::SER_W-1:0] stored,
  input  logic [sbp_pkg::SER_W-1:0] key,
  input  logic                      desc,
  output sbp_pkg::sbp_cmp_t         flags
);
  import sbp_pkg::*;

  logic lt;

  // One magnitude compare serves both list orders
  assign lt         = stored < key;
  assign flags.eq   = stored == key;
  assign flags.stop = desc ? (lt | flags.eq) : ~lt;

endmodule

/* src/sorted_block_pool_core.sv */
// Top level of the sorted block pool: sequencer, list storage and counters.
//
// Pool of eight fixed blocks handed out as node indices, with a LIFO free
// list and a used list kept sorted by serial number. A transaction is taken
// when start is high and busy is low; busy then stays high until the result
// has been shown. Every transaction gives exactly one result, shown on
// out_item for a single cycle with out_strobe high; it cannot be held off,
// so the receiver must take it in that cycle. Pop head and free need no walk.
// Pop by serial walks the entries before the match (up to used_count). Alloc
// first scans the used list for a duplicate when dup_check is set, then takes
// the free head, walks the entries before the insertion point and links the
// node in, with a second link write when an entry was passed. Every walk step
// is one read of the link and serial storage and one pass through the single
// shared serial comparator. desc_r (descending order) is written through cfg_we; the
// user must do so only while busy is low, as the block does not enforce it.
module sorted_block_pool_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  sbp_pkg::sbp_in_t  in_item,
  output logic              out_strobe,
  output sbp_pkg::sbp_out_t out_item,
  input  logic              cfg_we,
  input  logic              cfg_wdata
);
  import sbp_pkg::*;

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DUP  = 3'd1;
  localparam logic [2:0] S_ACHK = 3'd2;
  localparam logic [2:0] S_INS  = 3'd3;
  localparam logic [2:0] S_LNK1 = 3'd4;
  localparam logic [2:0] S_LNK2 = 3'd5;
  localparam logic [2:0] S_POP  = 3'd6;
  localparam logic [2:0] S_RESP = 3'd7;

  logic [2:0]        state_r, state_nxt;
  sbp_in_t           item_r, item_nxt;
  logic [NODE_W-1:0] cur_r, cur_nxt;
  logic [NODE_W-1:0] prev_r, prev_nxt;
  logic              have_prev_r, have_prev_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic [NODE_W-1:0] node_r, node_nxt;
  logic              ok_r, ok_nxt;
  logic [NODE_W-1:0] free_head_r, free_head_nxt;
  logic [NODE_W-1:0] used_head_r, used_head_nxt;
  logic [CNT_W-1:0]  free_total_r, free_total_nxt;
  logic [CNT_W-1:0]  used_total_r, used_total_nxt;
  logic [NODES-1:0]  held_r, held_nxt;
  logic              desc_r;

  logic [NODE_W-1:0] link_r [NODES];
  logic [SER_W-1:0]  serial_mem [NODES];

  logic              link_we;
  logic [NODE_W-1:0] link_waddr, link_wdata;
  logic              ser_we;
  logic [NODE_W-1:0] ser_waddr;
  logic [NODE_W-1:0] rd_addr;
  logic [NODE_W-1:0] link_rd;
  logic [SER_W-1:0]  serial_rd;
  sbp_cmp_t          cmp;

  // Read address of the link store; the serial store is read at cur_r
  always_comb begin
    case (state_r)
      S_IDLE:  rd_addr = used_head_r;
      S_ACHK:  rd_addr = free_head_r;
      S_LNK1:  rd_addr = prev_r;
      default: rd_addr = cur_r;
    endcase
  end

  assign link_rd   = link_r[rd_addr];
  assign serial_rd = serial_mem[cur_r];

  sbp_cmp u_cmp (
    .stored (serial_rd),
    .key    (item_r.serial_number),
    .desc   (desc_r),
    .flags  (cmp)
  );

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    have_prev_nxt  = have_prev_r;
    k_nxt          = k_r;
    node_nxt       = node_r;
    ok_nxt         = ok_r;
    free_head_nxt  = free_head_r;
    used_head_nxt  = used_head_r;
    free_total_nxt = free_total_r;
    used_total_nxt = used_total_r;
    held_nxt       = held_r;
    link_we        = 1'b0;
    link_waddr     = cur_r;
    link_wdata     = link_rd;
    ser_we         = 1'b0;
    ser_waddr      = free_head_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          item_nxt      = in_item;
          cur_nxt       = used_head_r;
          k_nxt         = '0;
          have_prev_nxt = 1'b0;
          ok_nxt        = 1'b0;
          node_nxt      = '0;
          case (in_item.mode)
            MODE_ALLOC:   state_nxt = in_item.dup_check ? S_DUP : S_ACHK;
            MODE_POP_SER: state_nxt = S_POP;
            MODE_POP_HD: begin
              state_nxt = S_RESP;
              if (used_total_r != '0) begin
                node_nxt               = used_head_r;
                used_head_nxt          = link_rd;
                used_total_nxt         = used_total_r - CNT_W'(1);
                held_nxt[used_head_r]  = 1'b1;
                ok_nxt                 = 1'b1;
              end
            end
            default: begin
              state_nxt = S_RESP;
              if (held_r[in_item.node_index]) begin
                held_nxt[in_item.node_index] = 1'b0;
                link_we        = 1'b1;
                link_waddr     = in_item.node_index;
                link_wdata     = free_head_r;
                free_head_nxt  = in_item.node_index;
                free_total_nxt = free_total_r + CNT_W'(1);
                ok_nxt         = 1'b1;
              end
            end
          endcase
        end
      end

      // Duplicate scan of the used list
      S_DUP: begin
        if (k_r == used_total_r) begin
          state_nxt = S_ACHK;
        end else if (cmp.eq) begin
          state_nxt = S_RESP;
        end else begin
          cur_nxt = link_rd;
          k_nxt   = k_r + CNT_W'(1);
        end
      end

      // Take the free head and stamp its serial
      S_ACHK: begin
        if (free_total_r == '0) begin
          state_nxt = S_RESP;
        end else begin
          node_nxt       = free_head_r;
          free_head_nxt  = link_rd;
          free_total_nxt = free_total_r - CNT_W'(1);
          ser_we         = 1'b1;
          ser_waddr      = free_head_r;
          cur_nxt        = used_head_r;
          k_nxt          = '0;
          have_prev_nxt  = 1'b0;
          state_nxt      = S_INS;
        end
      end

      // Find the insertion point
      S_INS: begin
        if (k_r == used_total_r || cmp.stop) begin
          state_nxt = S_LNK1;
        end else begin
          prev_nxt      = cur_r;
          have_prev_nxt = 1'b1;
          cur_nxt       = link_rd;
          k_nxt         = k_r + CNT_W'(1);
        end
      end

      // Splice in: new node takes the successor
      S_LNK1: begin
        link_we    = 1'b1;
        link_waddr = node_r;
        if (have_prev_r) begin
          link_wdata = link_rd;
          state_nxt  = S_LNK2;
        end else begin
          link_wdata     = used_head_r;
          used_head_nxt  = node_r;
          used_total_nxt = used_total_r + CNT_W'(1);
          ok_nxt         = 1'b1;
          state_nxt      = S_RESP;
        end
      end

      // Splice in: predecessor points at the new node
      S_LNK2: begin
        link_we        = 1'b1;
        link_waddr     = prev_r;
        link_wdata     = node_r;
        used_total_nxt = used_total_r + CNT_W'(1);
        ok_nxt         = 1'b1;
        state_nxt      = S_RESP;
      end

      // Pop by serial: first match is unlinked
      S_POP: begin
        if (k_r == used_total_r) begin
          state_nxt = S_RESP;
        end else if (cmp.eq) begin
          if (have_prev_r) begin
            link_we    = 1'b1;
            link_waddr = prev_r;
            link_wdata = link_rd;
          end else begin
            used_head_nxt = link_rd;
          end
          used_total_nxt = used_total_r - CNT_W'(1);
          held_nxt[cur_r] = 1'b1;
          node_nxt        = cur_r;
          ok_nxt          = 1'b1;
          state_nxt       = S_RESP;
        end else begin
          prev_nxt      = cur_r;
          have_prev_nxt = 1'b1;
          cur_nxt       = link_rd;
          k_nxt         = k_r + CNT_W'(1);
        end
      end

      S_RESP:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      free_head_r  <= '0;
      used_head_r  <= '0;
      free_total_r <= CNT_W'(NODES);
      used_total_r <= '0;
      held_r       <= '0;
      desc_r       <= 1'b0;
      ok_r         <= 1'b0;
      node_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      free_head_r  <= free_head_nxt;
      used_head_r  <= used_head_nxt;
      free_total_r <= free_total_nxt;
      used_total_r <= used_total_nxt;
      held_r       <= held_nxt;
      ok_r         <= ok_nxt;
      node_r       <= node_nxt;
      if (cfg_we) begin
        desc_r <= cfg_wdata;
      end
    end
  end

  // Walk registers and latched transaction
  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    cur_r       <= cur_nxt;
    prev_r      <= prev_nxt;
    have_prev_r <= have_prev_nxt;
    k_r         <= k_nxt;
  end

  // Link store: reset chains node i to (i+1) mod NODES
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NODES; i++) begin
        link_r[i] <= NODE_W'((i + 1) % NODES);
      end
    end else if (link_we) begin
      link_r[link_waddr] <= link_wdata;
    end
  end

  // Serial store, no reset
  always_ff @(posedge clk) begin
    if (ser_we) begin
      serial_mem[ser_waddr] <= item_r.serial_number;
    end
  end

  // Result outputs
  assign busy                = state_r != S_IDLE;
  assign out_strobe          = state_r == S_RESP;
  assign out_item.ok         = ok_r;
  assign out_item.node_out   = ok_r ? node_r : '0;
  assign out_item.used_count = used_total_r;
  assign out_item.free_count = free_total_r;

`ifndef ASSERT_OFF
  // Between taking the free head and splicing it in, one node sits in neither list
  a_node_conservation: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |->
      ((32'(used_total_r) + 32'(free_total_r) + 32'($countones(held_r))) == 32'(NODES)))
    else $error("node count not conserved");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  a_fail_node_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_item.ok) |-> (out_item.node_out == '0))
    else $error("node_out not zero on failed transaction");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DUP || state_r == S_INS || state_r == S_POP) |->
      (k_r <= used_total_r))
    else $error("list walk ran past used count");
`endif

endmodule

/* test/tb.sv */
// Testbench for sorted_block_pool_core: queued requests, result checking against a pool model.
`timescale 1ns / 1ps

module tb;
  import sbp_pkg::*;

  // Model of the pool state: serial, link and held flag per node, both list heads and counts, sort order
  typedef struct packed {
    logic [NODES-1:0][SER_W-1:0]  serial;
    logic [NODES-1:0][NODE_W-1:0] link;
    logic [NODES-1:0]             held;
    logic [NODE_W-1:0]            free_head;
    logic [NODE_W-1:0]            used_head;
    logic [CNT_W-1:0]             free_total;
    logic [CNT_W-1:0]             used_total;
    logic                         desc;
  } pool_t;

  localparam int SETTLE = 30;  // idle wait after the last result of each drain

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  sbp_in_t  in_item = '0;
  logic     out_strobe;
  sbp_out_t out_item;
  logic     cfg_we = 1'b0;
  logic     cfg_wdata = 1'b0;

  sbp_in_t  pending_requests[$];
  sbp_out_t pending_results[$];
  pool_t    check_pool;   // advanced on each accepted transaction
  pool_t    gen_pool;     // advanced as requests are queued, steers the stimulus

  int idle_left = 0;
  bit burst_mode = 1'b0;
  int fail_count = 0;
  int ok_tally = 0;
  int order_writes = 0;
  int mode_tally[4] = '{0, 0, 0, 0};

  sorted_block_pool_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Pool state straight out of reset
  function automatic pool_t pool_cleared();
    pool_t p;
    p = '0;
    for (int i = 0; i < NODES; i++) begin
      p.link[i] = NODE_W'(i + 1);
    end
    p.free_total = CNT_W'(NODES);
    return p;
  endfunction

  // Applies one transaction to the pool and returns the result it gives
  function automatic sbp_out_t pool_apply(inout pool_t p, input sbp_in_t t);
    sbp_out_t          r;
    logic [NODE_W-1:0] cur, prev, node;
    bit                have_prev, hit, stop_here;
    r = '0;
    prev = '0;
    node = '0;
    have_prev = 1'b0;
    hit = 1'b0;
    stop_here = 1'b0;
    case (t.mode)
      MODE_ALLOC: begin
        if (t.dup_check) begin
          cur = p.used_head;
          for (int k = 0; k < p.used_total && !hit; k++) begin
            if (p.serial[cur] == t.serial_number) hit = 1'b1;
            cur = p.link[cur];
          end
        end
        if (!hit && p.free_total != 0) begin
          node = p.free_head;
          p.free_head = p.link[node];
          p.free_total--;
          p.serial[node] = t.serial_number;
          // insertion point lies ahead of the first entry equal or beyond the key
          cur = p.used_head;
          for (int k = 0; k < p.used_total && !stop_here; k++) begin
            if (p.desc ? (p.serial[cur] <= t.serial_number)
                       : (p.serial[cur] >= t.serial_number)) begin
              stop_here = 1'b1;
            end else begin
              prev = cur;
              have_prev = 1'b1;
              cur = p.link[cur];
            end
          end
          if (have_prev) begin
            p.link[node] = p.link[prev];
            p.link[prev] = node;
          end else begin
            p.link[node] = p.used_head;
            p.used_head = node;
          end
          p.used_total++;
          r.ok = 1'b1;
        end
      end
      MODE_POP_SER: begin
        cur = p.used_head;
        for (int k = 0; k < p.used_total && !hit; k++) begin
          if (p.serial[cur] == t.serial_number) begin
            hit = 1'b1;
            if (have_prev) p.link[prev] = p.link[cur];
            else p.used_head = p.link[cur];
            p.used_total--;
            p.held[cur] = 1'b1;
            node = cur;
            r.ok = 1'b1;
          end else begin
            prev = cur;
            have_prev = 1'b1;
            cur = p.link[cur];
          end
        end
      end
      MODE_POP_HD: begin
        if (p.used_total != 0) begin
          node = p.used_head;
          p.used_head = p.link[node];
          p.used_total--;
          p.held[node] = 1'b1;
          r.ok = 1'b1;
        end
      end
      default: begin
        if (p.held[t.node_index]) begin
          p.held[t.node_index] = 1'b0;
          p.link[t.node_index] = p.free_head;
          p.free_head = t.node_index;
          p.free_total++;
          r.ok = 1'b1;
        end
      end
    endcase
    r.node_out = r.ok ? node : '0;
    r.used_count = p.used_total;
    r.free_count = p.free_total;
    return r;
  endfunction

  function automatic void queue_request(input logic [1:0] m, input logic [SER_W-1:0] s,
                                        input logic d, input logic [NODE_W-1:0] n);
    sbp_in_t  t;
    sbp_out_t ignored;
    t.mode = m;
    t.serial_number = s;
    t.dup_check = d;
    t.node_index = n;
    pending_requests.push_back(t);
    ignored = pool_apply(gen_pool, t);
  endfunction

  // Many small keys so that equal serials and duplicates turn up often
  function automatic logic [SER_W-1:0] pick_serial();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) return SER_W'($urandom_range(0, 5));
    if (roll == 4) return '1 - SER_W'($urandom_range(0, 2));
    return $urandom;
  endfunction

  // One random request, aimed at serials in the used list and nodes being held
  function automatic void queue_random(input int alloc_pct);
    logic [1:0]        m;
    logic [SER_W-1:0]  s;
    logic [NODE_W-1:0] n, cur;
    int                roll, pick, held_n;
    m = 2'($urandom_range(0, 3));
    s = $urandom;
    n = NODE_W'($urandom_range(0, NODES - 1));
    roll = $urandom_range(0, 99);
    if (roll >= 5) begin
      if (roll < 5 + alloc_pct) begin
        m = MODE_ALLOC;
        s = pick_serial();
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 40) begin
          m = MODE_POP_SER;
          s = pick_serial();
          if (gen_pool.used_total != 0 && $urandom_range(0, 3) != 0) begin
            pick = $urandom_range(0, int'(gen_pool.used_total) - 1);
            cur = gen_pool.used_head;
            for (int k = 0; k < pick; k++) cur = gen_pool.link[cur];
            s = gen_pool.serial[cur];
          end
        end else if (roll < 65) begin
          m = MODE_POP_HD;
        end else begin
          m = MODE_FREE;
          held_n = $countones(gen_pool.held);
          if (held_n != 0 && $urandom_range(0, 3) != 0) begin
            pick = $urandom_range(0, held_n - 1);
            for (int k = 0; k < NODES; k++) begin
              if (gen_pool.held[k]) begin
                if (pick == 0) n = NODE_W'(k);
                pick--;
              end
            end
          end
        end
      end
    end
    queue_request(m, s, 1'($urandom_range(0, 1)), n);
  endfunction

  task automatic write_order(input logic v);
    while (busy) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    check_pool.desc = v;
    gen_pool.desc = v;
    order_writes++;
  endtask

  // Wait for every queued request to be taken and every result to come back
  task automatic drain();
    while (pending_requests.size() != 0 || start || pending_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Driver: predicts on acceptance, then presents the next request after its gap
  always @(posedge clk) begin : driver
    logic taken;
    taken = start && !busy;
    if (taken) begin
      pending_results.push_back(pool_apply(check_pool, in_item));
      mode_tally[in_item.mode]++;
    end
    if (!rst_n || (start && !taken)) begin
      // hold
    end else if (idle_left > 0) begin
      idle_left--;
      start <= 1'b0;
    end else if (pending_requests.size() != 0) begin
      in_item <= pending_requests.pop_front();
      start <= 1'b1;
      if ($urandom_range(0, 39) == 0) burst_mode = !burst_mode;
      idle_left = burst_mode ? 0 : $urandom_range(0, 9);
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: each strobed result against the oldest expectation
  always @(posedge clk) begin : monitor
    sbp_out_t want;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: result with none expected: ok=%0d node=%0d used=%0d free=%0d",
                   $time, out_item.ok, out_item.node_out, out_item.used_count,
                   out_item.free_count);
      end else begin
        want = pending_results.pop_front();
        if (want.ok) ok_tally++;
        if (out_item.ok !== want.ok || out_item.node_out !== want.node_out ||
            out_item.used_count !== want.used_count ||
            out_item.free_count !== want.free_count) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: expected ok=%0d node=%0d used=%0d free=%0d, got ok=%0d node=%0d used=%0d free=%0d",
                     $time, want.ok, want.node_out, want.used_count, want.free_count,
                     out_item.ok, out_item.node_out, out_item.used_count,
                     out_item.free_count);
        end
      end
    end
  end

  initial begin : control
    int alloc_mix[6];
    alloc_mix = '{45, 30, 60, 45, 35, 55};
    check_pool = pool_cleared();
    gen_pool = pool_cleared();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_order(1'b0);

    // Directed: empty list, not held, duplicates, equal serials, full pool
    queue_request(MODE_POP_HD,  '0, 1'b0, 3'd0);           // pop head on empty list
    queue_request(MODE_POP_SER, '0, 1'b1, 3'd0);           // pop by serial on empty list
    queue_request(MODE_FREE,    '0, 1'b0, 3'd0);           // free of a node never popped
    queue_request(MODE_ALLOC,   '0, 1'b0, 3'd7);
    queue_request(MODE_ALLOC,   '1, 1'b1, 3'd0);
    queue_request(MODE_ALLOC,   '0, 1'b1, 3'd0);           // duplicate refused
    queue_request(MODE_ALLOC,   '0, 1'b0, 3'd0);           // equal serial goes ahead
    queue_request(MODE_ALLOC,   32'h8000_0000, 1'b1, 3'd0);
    queue_request(MODE_ALLOC,   32'hAAAA_AAAA, 1'b0, 3'd0);
    queue_request(MODE_ALLOC,   32'h5555_5555, 1'b1, 3'd0);
    queue_request(MODE_ALLOC,   32'd7, 1'b0, 3'd0);
    queue_request(MODE_ALLOC,   32'd3, 1'b0, 3'd0);
    queue_request(MODE_ALLOC,   32'd1, 1'b0, 3'd0);        // pool full
    queue_request(MODE_POP_SER, 32'd12345, 1'b0, 3'd0);    // serial not found
    queue_request(MODE_POP_SER, 32'hAAAA_AAAA, 1'b0, 3'd0);
    queue_request(MODE_POP_HD,  '0, 1'b0, 3'd0);
    queue_request(MODE_FREE,    '0, 1'b0, 3'd4);
    queue_request(MODE_FREE,    '0, 1'b0, 3'd4);           // already freed
    queue_request(MODE_FREE,    '0, 1'b0, 3'd2);
    queue_request(MODE_FREE,    '0, 1'b0, 3'd7);           // still in used list
    queue_request(MODE_POP_SER, '0, 1'b1, 3'd0);
    queue_request(MODE_POP_HD,  '0, 1'b0, 3'd0);
    queue_request(MODE_FREE,    '1, 1'b1, 3'd0);
    queue_request(MODE_FREE,    '1, 1'b1, 3'd7);
    drain();

    // Random phases, sort order alternating, alloc share varied to hit full and empty
    for (int ph = 0; ph < 6; ph++) begin
      write_order((ph % 2 == 0) ? 1'b1 : 1'b0);
      for (int i = 0; i < 305; i++) queue_random(alloc_mix[ph]);
      drain();
    end

    fail_count += pending_results.size();
    $display("covered %0d transactions: %0d alloc, %0d pop by serial, %0d pop head, %0d free",
             mode_tally[0] + mode_tally[1] + mode_tally[2] + mode_tally[3],
             mode_tally[MODE_ALLOC], mode_tally[MODE_POP_SER], mode_tally[MODE_POP_HD],
             mode_tally[MODE_FREE]);
    $display("%0d succeeded, %0d order writes across ascending and descending lists",
             ok_tally, order_writes);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #5000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* sim.f */
src/sbp_pkg.sv
src/sbp_cmp.sv
src/sorted_block_pool_core.sv
test/tb.sv
